// ----- src/dwmd_pkg.sv -----
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared types and constants for the double-ended queue with match delete.
// ----------------------------------------------------------------------------
`default_nettype none

package dwmd_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic [1:0] OP_PREPEND = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_DEQUEUE = 2'd2;
   localparam logic [1:0] OP_DELETE  = 2'd3;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [1:0]            op;
      logic [DATA_WIDTH-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic                   status;
      logic [DATA_WIDTH-1:0]  item_out;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

   // Per-cycle command broadcast to every cell; each bit already qualified.
   typedef struct packed {
      logic prepend;
      logic append;
      logic dequeue;
      logic delete;
   } cell_ctrl_type;

   // Where a cell sits relative to the stored run.
   typedef struct packed {
      logic valid;
      logic tail;
   } cell_pos_type;

endpackage

`default_nettype wire

// ----- src/deque_with_match_delete.sv -----
// ----------------------------------------------------------------------------
// deque_with_match_delete
// Bounded double-ended queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one operation:
//   prepend, append, dequeue front, or delete the first word equal to
//   item_value. rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly
//   one response per request: fail status, removed word, and new count.
//   A request accepted at one edge has its response registered and valid
//   after that edge. Throughput is one request per cycle while the receiver
//   takes responses; every cell compares and shifts in the same cycle, so the row
//   updates in a single step for any operation.
//   req_ready is high while the response register is empty or being
//   drained in the same cycle; a stalled receiver holds the response and
//   backs up the request channel after one entry.
//   Reset empties the queue (count zero) and drops any pending response.
//   Stored words are not cleared; they are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_match_delete (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  dwmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dwmd_pkg::rsp_type rsp_data
);

   localparam int DW = dwmd_pkg::DATA_WIDTH;
   localparam int CW = dwmd_pkg::COUNT_WIDTH;
   localparam int N  = dwmd_pkg::DEPTH;

   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dwmd_pkg::rsp_type rsp_ff, rsp_in;

   logic                   go, full, empty;
   dwmd_pkg::cell_ctrl_type ctrl;
   logic [DW-1:0]          words   [N];
   logic [N:0]             seen;
   logic [DW-1:0]          removed [N+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign go        = req_valid && req_ready;
   assign full      = (count_ff == CW'(N));
   assign empty     = (count_ff == '0);

   assign ctrl.prepend = go && (req_data.op == dwmd_pkg::OP_PREPEND) && !full;
   assign ctrl.append  = go && (req_data.op == dwmd_pkg::OP_APPEND) && !full;
   assign ctrl.dequeue = go && (req_data.op == dwmd_pkg::OP_DEQUEUE) && !empty;
   assign ctrl.delete  = go && (req_data.op == dwmd_pkg::OP_DELETE);

   assign seen[0]    = 1'b0;
   assign removed[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         dwmd_pkg::cell_pos_type pos;
         logic [DW-1:0]          left_word;
         logic [DW-1:0]          right_word;

         assign pos.valid = (CW'(gi) < count_ff);
         assign pos.tail  = (CW'(gi) == count_ff);

         if (gi == 0) begin : g_head
            assign left_word = req_data.item_value;
         end else begin : g_body
            assign left_word = words[gi-1];
         end

         if (gi == N - 1) begin : g_end
            assign right_word = '0;
         end else begin : g_mid
            assign right_word = words[gi+1];
         end

         dwmd_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .pos         (pos),
            .key         (req_data.item_value),
            .left_word   (left_word),
            .right_word  (right_word),
            .seen_in     (seen[gi]),
            .removed_in  (removed[gi]),
            .word        (words[gi]),
            .seen_out    (seen[gi+1]),
            .removed_out (removed[gi+1])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (go) begin
         rsp_valid_in    = 1'b1;
         rsp_in.status   = dwmd_pkg::STATUS_FAIL;
         rsp_in.item_out = '0;
         case (req_data.op)
            dwmd_pkg::OP_PREPEND, dwmd_pkg::OP_APPEND: begin
               if (!full) begin
                  count_in      = count_ff + CW'(1);
                  rsp_in.status = dwmd_pkg::STATUS_OK;
               end
            end
            dwmd_pkg::OP_DEQUEUE: begin
               if (!empty) begin
                  count_in        = count_ff - CW'(1);
                  rsp_in.status   = dwmd_pkg::STATUS_OK;
                  rsp_in.item_out = words[0];
               end
            end
            dwmd_pkg::OP_DELETE: begin
               if (seen[N]) begin
                  count_in        = count_ff - CW'(1);
                  rsp_in.status   = dwmd_pkg::STATUS_OK;
                  rsp_in.item_out = removed[N];
               end
            end
            default: begin
               rsp_in.status = dwmd_pkg::STATUS_FAIL;
            end
         endcase
         rsp_in.count = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- src/dwmd_cell.sv -----
// ----------------------------------------------------------------------------
// dwmd_cell
// One queue slot: holds a word, compares it against the delete key, and
// loads from its left or right neighbor when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmd_cell (
   input  wire                             clock,
   input  dwmd_pkg::cell_ctrl_type         ctrl,
   input  dwmd_pkg::cell_pos_type          pos,
   input  wire [dwmd_pkg::DATA_WIDTH-1:0]  key,
   input  wire [dwmd_pkg::DATA_WIDTH-1:0]  left_word,
   input  wire [dwmd_pkg::DATA_WIDTH-1:0]  right_word,
   input  wire                             seen_in,
   input  wire [dwmd_pkg::DATA_WIDTH-1:0]  removed_in,
   output logic [dwmd_pkg::DATA_WIDTH-1:0] word,
   output logic                            seen_out,
   output logic [dwmd_pkg::DATA_WIDTH-1:0] removed_out
);

   logic [dwmd_pkg::DATA_WIDTH-1:0] word_ff;
   logic [dwmd_pkg::DATA_WIDTH-1:0] word_in;
   logic                            match;
   logic                            first;

   assign match       = pos.valid && (word_ff == key);
   assign first       = match && !seen_in;
   assign seen_out    = seen_in || match;
   assign removed_out = first ? word_ff : removed_in;
   assign word        = word_ff;

   always_comb begin
      word_in = word_ff;
      if (ctrl.prepend) begin
         word_in = left_word;
      end else if (ctrl.append && pos.tail) begin
         word_in = key;
      end else if (ctrl.dequeue) begin
         word_in = right_word;
      end else if (ctrl.delete && seen_out) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// ----- tb/deque_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the deque, keeps its own copy of the stored words,
// predicts one response per accepted request and compares it field by field.
// ----------------------------------------------------------------------------

module deque_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  dwmd_pkg::req_type req_data,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  dwmd_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending
);

   logic [dwmd_pkg::DATA_WIDTH-1:0] stored [dwmd_pkg::DEPTH];
   int                              stored_count;
   dwmd_pkg::rsp_type               predicted_rsps [$];

   initial begin
      mismatch_count = 0;
      pending        = 0;
      stored_count   = 0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100)
         $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void remove_word(input int pos);
      for (int i = pos; i + 1 < stored_count; i++)
         stored[i] = stored[i + 1];
      stored_count--;
   endfunction

   // Applies one request to the shadow deque, returns the response it causes.
   function automatic dwmd_pkg::rsp_type deque_apply(input dwmd_pkg::req_type r);
      dwmd_pkg::rsp_type res;
      int                hit;
      res.status   = dwmd_pkg::STATUS_FAIL;
      res.item_out = '0;
      hit          = -1;
      case (r.op)
         dwmd_pkg::OP_PREPEND: begin
            if (stored_count < dwmd_pkg::DEPTH) begin
               for (int i = stored_count; i > 0; i--)
                  stored[i] = stored[i - 1];
               stored[0] = r.item_value;
               stored_count++;
               res.status = dwmd_pkg::STATUS_OK;
            end
         end
         dwmd_pkg::OP_APPEND: begin
            if (stored_count < dwmd_pkg::DEPTH) begin
               stored[stored_count] = r.item_value;
               stored_count++;
               res.status = dwmd_pkg::STATUS_OK;
            end
         end
         dwmd_pkg::OP_DEQUEUE: begin
            if (stored_count > 0) begin
               res.item_out = stored[0];
               remove_word(0);
               res.status = dwmd_pkg::STATUS_OK;
            end
         end
         dwmd_pkg::OP_DELETE: begin
            for (int i = 0; i < stored_count; i++)
               if (hit < 0 && stored[i] == r.item_value)
                  hit = i;
            if (hit >= 0) begin
               res.item_out = stored[hit];
               remove_word(hit);
               res.status = dwmd_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      res.count = dwmd_pkg::COUNT_WIDTH'(stored_count);
      return res;
   endfunction

   always @(posedge clock) begin
      dwmd_pkg::rsp_type want;
      if (reset) begin
         stored_count = 0;
         predicted_rsps.delete();
      end else begin
         // response of an earlier request first: it never belongs to the request taken at this edge
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch($sformatf("response %p with none expected", rsp_data));
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %b, expected %b",
                                            rsp_data.status, want.status));
               if (rsp_data.item_out !== want.item_out)
                  report_mismatch($sformatf("item_out %h, expected %h",
                                            rsp_data.item_out, want.item_out));
               if (rsp_data.count !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_data.count, want.count));
            end
         end
         if (req_valid && req_ready === 1'b1)
            predicted_rsps.push_back(deque_apply(req_data));
      end
      pending <= predicted_rsps.size();
   end

endmodule

// ----- tb/tb_deque_with_match_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_match_delete
// Drives directed and random deque requests with random idle on both sides;
// a checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_deque_with_match_delete;

   localparam int DW         = dwmd_pkg::DATA_WIDTH;
   localparam int IDLE_PCT   = 13;
   localparam int POOL_SIZE  = 6;
   localparam int PHASES     = 10;
   localparam int PHASE_REQS = 100;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dwmd_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dwmd_pkg::rsp_type rsp_data;
   logic              calm      = 1'b0;
   int                mismatch_count;
   int                pending;

   logic [DW-1:0] word_pool [POOL_SIZE];

   deque_with_match_delete dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   deque_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Returns at the edge where the request is taken, valid still high.
   task automatic send_request(input logic [1:0] kind,
                               input logic [DW-1:0] word);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         req_data  <= dwmd_pkg::req_type'({2'($urandom), DW'($urandom)});
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= dwmd_pkg::req_type'({kind, word});
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_op(input int insert_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < insert_pct / 2)
         return dwmd_pkg::OP_PREPEND;
      if (roll < insert_pct)
         return dwmd_pkg::OP_APPEND;
      if (roll < insert_pct + (100 - insert_pct) / 2)
         return dwmd_pkg::OP_DEQUEUE;
      return dwmd_pkg::OP_DELETE;
   endfunction

   function automatic logic [DW-1:0] pick_word();
      if ($urandom_range(99) < 70)
         return word_pool[$urandom_range(POOL_SIZE - 1)];
      return DW'($urandom);
   endfunction

   initial begin
      int insert_pct;
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(dwmd_pkg::OP_DEQUEUE, '0);
      send_request(dwmd_pkg::OP_DELETE, '0);
      send_request(dwmd_pkg::OP_APPEND, 32'h0000_0005);
      send_request(dwmd_pkg::OP_DELETE, 32'h0000_0005);
      send_request(dwmd_pkg::OP_PREPEND, '1);
      send_request(dwmd_pkg::OP_APPEND, '0);
      send_request(dwmd_pkg::OP_PREPEND, 32'hAAAA_AAAA);
      send_request(dwmd_pkg::OP_APPEND, 32'h5555_5555);
      send_request(dwmd_pkg::OP_APPEND, '1);
      send_request(dwmd_pkg::OP_DELETE, '1);
      send_request(dwmd_pkg::OP_DELETE, 32'h1234_5678);
      send_request(dwmd_pkg::OP_DEQUEUE, '0);
      repeat (13) send_request(dwmd_pkg::OP_APPEND, DW'($urandom));
      send_request(dwmd_pkg::OP_PREPEND, 32'hDEAD_BEEF);
      send_request(dwmd_pkg::OP_APPEND, 32'h0BAD_F00D);
      wait_all_responses();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0:       insert_pct = 75;
            1:       insert_pct = 25;
            default: insert_pct = 50;
         endcase
         calm <= (phase == 4);
         foreach (word_pool[i])
            word_pool[i] = DW'($urandom);
         if (phase % 2 == 0) begin
            word_pool[0] = '0;
            word_pool[1] = '1;
         end
         repeat (PHASE_REQS) send_request(pick_op(insert_pct), pick_word());
         if (phase % 3 == 2)
            wait_all_responses();
      end

      req_valid <= 1'b0;
      calm      <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (pending != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending != 0)
            $display("%0d responses never arrived", pending);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- deque_with_match_delete.f -----
src/dwmd_pkg.sv
src/dwmd_cell.sv
src/deque_with_match_delete.sv
tb/deque_checker.sv
tb/tb_deque_with_match_delete.sv
